// ----- sv/bprd_pkg.sv -----
// shared types and constants for the buffer pool ring deque
package bprd_pkg;

  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 31;
  localparam int MODE_W    = 3;
  localparam int SEL_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int ALIGN_W   = 5;
  localparam int SLOT_W    = 2 * ADDR_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_REGISTER = 3'd0,
    MODE_RET_TAIL = 3'd1,
    MODE_RET_HEAD = 3'd2,
    MODE_TAKE     = 3'd3,
    MODE_SUB      = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_REJECT     = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_MISALIGNED = 2'd3
  } status_t;

  typedef enum logic [SEL_W-1:0] {
    SEL_EP1  = 3'd0,
    SEL_WPP  = 3'd1,
    SEL_EP2  = 3'd2,
    SEL_MAP  = 3'd3,
    SEL_DATA = 3'd4
  } sel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_EP1 = 2'd0,
    REG_SIZE_WPP = 2'd1,
    REG_SIZE_EP2 = 2'd2,
    REG_SIZE_MAP = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_TAKE  = 2'd1,
    KIND_SUB   = 2'd2
  } kind_t;

  typedef struct packed {
    status_t status;
    logic    take;
  } deque_res_t;

endpackage

// ----- sv/bprd_if.sv -----
// request and response channel interfaces
interface bprd_req_if import bprd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ADDR_W-1:0] buf_addr;
  logic [ADDR_W-1:0] buf_location;
  logic [SEL_W-1:0]  sub_select;

  modport source (output valid, mode, buf_addr, buf_location, sub_select, input ready);
  modport sink (input valid, mode, buf_addr, buf_location, sub_select, output ready);
endinterface

interface bprd_rsp_if import bprd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   out_addr;
  logic [ADDR_W-1:0]   out_location;
  logic [COUNT_W-1:0]  queued_count;
  logic [COUNT_W-1:0]  registered_count;

  modport source (output valid, status, out_addr, out_location, queued_count,
                  registered_count, input ready);
  modport sink (input valid, status, out_addr, out_location, queued_count,
                registered_count, output ready);
endinterface

// ----- sv/buffer_pool_ring_deque.sv -----
// buffer pool ring deque: request decode, result register and response channel
//
// usage: requests arrive on req (mode, buf_addr, buf_location, sub_select);
// each request gives exactly one item on rsp (status, out_addr, out_location,
// queued_count, registered_count). sub-buffer sizes are set through the
// cfg_we / cfg_index / cfg_data write port while no request is in flight.
// a request accepted at a clock edge shows its result on rsp right after
// that edge. throughput: one request per cycle while rsp is not stalled;
// each request makes at most one write or one read of the single slot ram.
// a take reads the head slot into the ram output register, and the
// sub-buffer address sum is finished on the registered offset at the output.
// when rsp stalls, the result is held and req.ready drops until rsp is taken;
// a result taken in a cycle frees room for a new request in that cycle.
// reset (rst, synchronous): counts and head index go to zero, sizes to zero,
// no result pending; slot contents are undefined until written.
module buffer_pool_ring_deque import bprd_pkg::*; #(
  parameter int POOL_DEPTH = 18
) (
  input  logic                 clk,
  input  logic                 rst,
  bprd_req_if.sink             req,
  bprd_rsp_if.source           rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  localparam int CW = $clog2(POOL_DEPTH + 1);

  logic              accept;
  deque_res_t        dq_res;
  logic [SLOT_W-1:0] rd_data;
  logic [CW-1:0]     queued;
  logic [CW-1:0]     registered;
  logic [ADDR_W-1:0] offset;
  logic              sel_ok;

  logic              rsp_valid;
  kind_t             kind;
  kind_t             kind_next;
  status_t           status;
  status_t           status_next;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] loc;
  logic [ADDR_W-1:0] off;

  logic [ADDR_W-1:0] sub_addr;
  logic [ADDR_W-1:0] sub_loc;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  bprd_deque #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_deque (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .mode       (req.mode),
    .wr_data    ({req.buf_addr, req.buf_location}),
    .res        (dq_res),
    .rd_data    (rd_data),
    .queued     (queued),
    .registered (registered)
  );

  bprd_offset u_offset (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sub_select (req.sub_select),
    .offset     (offset),
    .sel_ok     (sel_ok)
  );

  always_comb begin
    kind_next   = KIND_PLAIN;
    status_next = dq_res.status;
    if (req.mode == MODE_TAKE && dq_res.take) begin
      kind_next = KIND_TAKE;
    end else if (req.mode == MODE_SUB) begin
      if (sel_ok) begin
        kind_next = KIND_SUB;
      end else begin
        status_next = ST_REJECT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind   <= kind_next;
      status <= status_next;
      addr   <= req.buf_addr;
      loc    <= req.buf_location;
      off    <= offset;
    end
  end

  assign sub_addr = addr + off;
  assign sub_loc  = loc + off;

  always_comb begin
    rsp.status       = status;
    rsp.out_addr     = '0;
    rsp.out_location = '0;
    case (kind)
      KIND_TAKE: begin
        rsp.out_addr     = rd_data[SLOT_W-1:ADDR_W];
        rsp.out_location = rd_data[ADDR_W-1:0];
      end
      KIND_SUB: begin
        rsp.out_addr     = sub_addr;
        rsp.out_location = sub_loc;
        rsp.status       = (sub_addr[ALIGN_W-1:0] != '0) ? ST_MISALIGNED : ST_OK;
      end
      default: begin
        rsp.status = status;
      end
    endcase
  end

  // counts only move on accept, so they already hold this item's update
  assign rsp.valid            = rsp_valid;
  assign rsp.queued_count     = COUNT_W'(queued);
  assign rsp.registered_count = COUNT_W'(registered);

endmodule

// ----- sv/bprd_ram.sv -----
// generic single-port-write ram with registered read
module bprd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 18,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/bprd_deque.sv -----
// deque pointers, counts and slot storage
module bprd_deque import bprd_pkg::*; #(
  parameter int POOL_DEPTH = 18,
  localparam int IW = $clog2(POOL_DEPTH),
  localparam int CW = $clog2(POOL_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [MODE_W-1:0] mode,
  input  logic [SLOT_W-1:0] wr_data,
  output deque_res_t        res,
  output logic [SLOT_W-1:0] rd_data,
  output logic [CW-1:0]     queued,
  output logic [CW-1:0]     registered
);

  localparam logic [IW:0]   DEPTH_L = (IW + 1)'(POOL_DEPTH);
  localparam logic [IW-1:0] LAST_L  = IW'(POOL_DEPTH - 1);
  localparam logic [CW-1:0] FULL_L  = CW'(POOL_DEPTH);

  logic [IW-1:0] head;
  logic [IW-1:0] head_next;
  logic [CW-1:0] queued_next;
  logic [CW-1:0] registered_next;

  logic [IW:0]   tail_sum;
  logic [IW-1:0] tail;
  logic [IW-1:0] head_dec;
  logic [IW-1:0] head_inc;

  logic          we;
  logic [IW-1:0] waddr;
  logic          re;

  // tail = (head + queued) mod depth, sum stays below twice the depth
  assign tail_sum = (IW + 1)'(head) + (IW + 1)'(queued);
  assign tail     = (tail_sum >= DEPTH_L) ? IW'(tail_sum - DEPTH_L) : IW'(tail_sum);
  assign head_dec = (head == '0) ? LAST_L : head - 1'b1;
  assign head_inc = (head == LAST_L) ? '0 : head + 1'b1;

  always_comb begin
    head_next       = head;
    queued_next     = queued;
    registered_next = registered;
    we              = 1'b0;
    waddr           = tail;
    re              = 1'b0;
    res.status      = ST_OK;
    res.take        = 1'b0;
    case (mode)
      MODE_REGISTER: begin
        if (registered < FULL_L) begin
          we              = accept;
          queued_next     = queued + 1'b1;
          registered_next = registered + 1'b1;
        end else begin
          res.status = ST_REJECT;
        end
      end
      MODE_RET_TAIL: begin
        if (queued < registered) begin
          we          = accept;
          queued_next = queued + 1'b1;
        end else begin
          res.status = ST_REJECT;
        end
      end
      MODE_RET_HEAD: begin
        if (queued < registered) begin
          we          = accept;
          waddr       = head_dec;
          head_next   = head_dec;
          queued_next = queued + 1'b1;
        end else begin
          res.status = ST_REJECT;
        end
      end
      MODE_TAKE: begin
        if (queued == '0) begin
          res.status = ST_EMPTY;
        end else begin
          re          = accept;
          res.take    = 1'b1;
          head_next   = head_inc;
          queued_next = queued - 1'b1;
        end
      end
      MODE_SUB: begin
        res.status = ST_OK;
      end
      default: begin
        res.status = ST_REJECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      queued     <= '0;
      registered <= '0;
    end else if (accept) begin
      head       <= head_next;
      queued     <= queued_next;
      registered <= registered_next;
    end
  end

  bprd_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (POOL_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_data),
    .re    (re),
    .raddr (head),
    .rdata (rd_data)
  );

  a_queued_le_registered: assert property (@(posedge clk) disable iff (rst)
    queued <= registered)
    else $error("queued count exceeds registered count");

  a_registered_le_depth: assert property (@(posedge clk) disable iff (rst)
    registered <= FULL_L)
    else $error("registered count exceeds pool depth");

  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    (IW + 1)'(head) < DEPTH_L)
    else $error("head index out of range");

  a_take_decrements: assert property (@(posedge clk) disable iff (rst)
    accept && res.take |=> queued == $past(queued) - 1'b1)
    else $error("take did not decrement queued count");

endmodule

// ----- sv/bprd_offset.sv -----
// sub-buffer size registers and offset sum
module bprd_offset import bprd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic [SEL_W-1:0]     sub_select,
  output logic [ADDR_W-1:0]    offset,
  output logic                 sel_ok
);

  logic [SIZE_W-1:0] size_ep1;
  logic [SIZE_W-1:0] size_wpp;
  logic [SIZE_W-1:0] size_ep2;
  logic [SIZE_W-1:0] size_map;

  logic [ADDR_W-1:0] term_ep1;
  logic [ADDR_W-1:0] term_wpp;
  logic [ADDR_W-1:0] term_ep2;
  logic [ADDR_W-1:0] term_map;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_ep1 <= '0;
      size_wpp <= '0;
      size_ep2 <= '0;
      size_map <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_EP1: size_ep1 <= cfg_data;
        REG_SIZE_WPP: size_wpp <= cfg_data;
        REG_SIZE_EP2: size_ep2 <= cfg_data;
        REG_SIZE_MAP: size_map <= cfg_data;
        default: ;
      endcase
    end
  end

  // each sub-buffer starts after all those listed before it
  always_comb begin
    term_ep1 = (sub_select inside {[SEL_WPP:SEL_DATA]}) ? ADDR_W'(size_ep1) : '0;
    term_wpp = (sub_select inside {[SEL_EP2:SEL_DATA]}) ? ADDR_W'(size_wpp) : '0;
    term_ep2 = (sub_select inside {[SEL_MAP:SEL_DATA]}) ? ADDR_W'(size_ep2) : '0;
    term_map = (sub_select == SEL_DATA) ? ADDR_W'(size_map) : '0;
    sel_ok   = sub_select inside {[SEL_EP1:SEL_DATA]};
  end

  assign offset = (term_ep1 + term_wpp) + (term_ep2 + term_map);

endmodule

// ----- bench/bprd_pool_checker.sv -----
// checker: mirrors the buffer pool, predicts each response and compares it
module bprd_pool_checker import bprd_pkg::*; #(
  parameter int POOL_DEPTH = 18
) (
  input  logic                 clk,
  input  logic                 rst,
  bprd_req_if                  req,
  bprd_rsp_if                  rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
    logic [ADDR_W-1:0]   location;
    logic [COUNT_W-1:0]  queued;
    logic [COUNT_W-1:0]  registered;
  } pool_result_t;

  logic [SIZE_W-1:0] sub_sizes [4];
  logic [ADDR_W-1:0] slot_addr [POOL_DEPTH];
  logic [ADDR_W-1:0] slot_loc [POOL_DEPTH];
  int                head;
  int                queued;
  int                registered;
  pool_result_t      expected_q [$];

  function automatic void push_tail(logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] location);
    int slot;
    slot = (head + queued) % POOL_DEPTH;
    slot_addr[slot] = addr;
    slot_loc[slot]  = location;
    queued++;
  endfunction

  function automatic pool_result_t pool_apply(logic [MODE_W-1:0] mode,
                                              logic [ADDR_W-1:0] addr,
                                              logic [ADDR_W-1:0] location,
                                              logic [SEL_W-1:0]  sel);
    pool_result_t      r;
    logic [ADDR_W-1:0] offset;
    r        = '0;
    r.status = ST_OK;
    case (mode)
      MODE_REGISTER: begin
        if (registered < POOL_DEPTH) begin
          push_tail(addr, location);
          registered++;
        end else begin
          r.status = ST_REJECT;
        end
      end
      MODE_RET_TAIL: begin
        if (queued < registered) push_tail(addr, location);
        else r.status = ST_REJECT;
      end
      MODE_RET_HEAD: begin
        if (queued < registered) begin
          head = (head == 0) ? POOL_DEPTH - 1 : head - 1;
          slot_addr[head] = addr;
          slot_loc[head]  = location;
          queued++;
        end else begin
          r.status = ST_REJECT;
        end
      end
      MODE_TAKE: begin
        if (queued == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.addr     = slot_addr[head];
          r.location = slot_loc[head];
          queued--;
          head = (head + 1) % POOL_DEPTH;
        end
      end
      MODE_SUB: begin
        if (sel <= SEL_DATA) begin
          // offset is the sum of all sub-buffers in front of the selected one
          offset = '0;
          if (sel >= SEL_WPP)  offset += ADDR_W'(sub_sizes[REG_SIZE_EP1]);
          if (sel >= SEL_EP2)  offset += ADDR_W'(sub_sizes[REG_SIZE_WPP]);
          if (sel >= SEL_MAP)  offset += ADDR_W'(sub_sizes[REG_SIZE_EP2]);
          if (sel >= SEL_DATA) offset += ADDR_W'(sub_sizes[REG_SIZE_MAP]);
          r.addr     = addr + offset;
          r.location = location + offset;
          if (r.addr[ALIGN_W-1:0] != '0) r.status = ST_MISALIGNED;
        end else begin
          r.status = ST_REJECT;
        end
      end
      default: r.status = ST_REJECT;
    endcase
    r.queued     = COUNT_W'(queued);
    r.registered = COUNT_W'(registered);
    return r;
  endfunction

  task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    pool_result_t want;
    if (rst) begin
      sub_sizes  = '{default: '0};
      head       = 0;
      queued     = 0;
      registered = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) sub_sizes[cfg_index] = cfg_data;
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: response with no item waiting: status %0d addr %h loc %h",
                   $time, rsp.status, rsp.out_addr, rsp.out_location);
        end else begin
          want = expected_q.pop_front();
          check_field("status", ADDR_W'(want.status), ADDR_W'(rsp.status));
          check_field("out_addr", want.addr, rsp.out_addr);
          check_field("out_location", want.location, rsp.out_location);
          check_field("queued_count", ADDR_W'(want.queued), ADDR_W'(rsp.queued_count));
          check_field("registered_count", ADDR_W'(want.registered),
                      ADDR_W'(rsp.registered_count));
        end
      end
      if (req.valid && req.ready)
        expected_q.push_back(pool_apply(req.mode, req.buf_addr, req.buf_location,
                                        req.sub_select));
    end
    outstanding = expected_q.size();
  end

endmodule

// ----- bench/buffer_pool_ring_deque_tb.sv -----
// testbench top: clock, reset, request and size stimulus, final verdict
module buffer_pool_ring_deque_tb import bprd_pkg::*; ();

  localparam int POOL_DEPTH   = 18;
  localparam int LIMIT_CYCLES = 400000;
  localparam int CHUNKS       = 6;
  localparam int CHUNK_ITEMS  = 105;
  localparam int TAIL_CYCLES  = 10;

  localparam logic [MODE_W-1:0] MODE_BAD_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_BAD_HI = 3'd7;
  localparam logic [SEL_W-1:0]  SEL_BAD_LO  = 3'd5;
  localparam logic [SEL_W-1:0]  SEL_BAD_HI  = 3'd7;
  localparam logic [SIZE_W-1:0] SIZE_MAX    = '1;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;
  int                   tx_idle_pct;
  int                   rx_idle_pct;
  int                   take_pct;
  int                   mismatches;
  int                   outstanding;
  int                   cycle_count;

  bprd_req_if req_ch ();
  bprd_rsp_if rsp_ch ();

  buffer_pool_ring_deque #(.POOL_DEPTH(POOL_DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bprd_pool_checker #(.POOL_DEPTH(POOL_DEPTH)) u_chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("buffer_pool_ring_deque: mismatch");
    $finish;
  end

  task automatic set_idle_profile(int profile);
    case (profile)
      0: begin
        tx_idle_pct = 22;
        rx_idle_pct = 63;
      end
      1: begin
        tx_idle_pct = 63;
        rx_idle_pct = 22;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [SIZE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  task automatic write_sizes(logic [SIZE_W-1:0] ep1, logic [SIZE_W-1:0] wpp,
                             logic [SIZE_W-1:0] ep2, logic [SIZE_W-1:0] map);
    write_reg(REG_SIZE_EP1, ep1);
    write_reg(REG_SIZE_WPP, wpp);
    write_reg(REG_SIZE_EP2, ep2);
    write_reg(REG_SIZE_MAP, map);
    cfg_we <= 1'b0;
  endtask

  // hold the sender until every response is back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic send_req(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr,
                          logic [ADDR_W-1:0] location, logic [SEL_W-1:0] sel);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.mode         <= mode;
    req_ch.buf_addr     <= addr;
    req_ch.buf_location <= location;
    req_ch.sub_select   <= sel;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    int                r;
    logic [MODE_W-1:0] mode;
    logic [SEL_W-1:0]  sel;
    logic [ADDR_W-1:0] addr;
    r = $urandom_range(0, 99);
    if (r < 8) mode = MODE_REGISTER;
    else if (r < 8 + take_pct) mode = MODE_TAKE;
    else if (r < 8 + take_pct + (92 - take_pct) * 3 / 10) mode = MODE_RET_TAIL;
    else if (r < 8 + take_pct + (92 - take_pct) * 6 / 10) mode = MODE_RET_HEAD;
    else if (r < 96) mode = MODE_SUB;
    else mode = MODE_W'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
    if ($urandom_range(0, 9) == 0) sel = SEL_W'($urandom_range(SEL_BAD_LO, SEL_BAD_HI));
    else sel = SEL_W'($urandom_range(SEL_EP1, SEL_DATA));
    addr = $urandom;
    if ($urandom_range(0, 1) == 1) addr[ALIGN_W-1:0] = '0;
    send_req(mode, addr, $urandom, sel);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size(int chunk);
    case (chunk)
      0: return '0;
      1: return SIZE_MAX;
      2: return SIZE_W'($urandom);
      3: return SIZE_W'({$urandom_range(0, 1023), 5'd0});
      4: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return SIZE_MAX;
          default: return SIZE_W'($urandom);
        endcase
      end
      default: return SIZE_W'($urandom_range(0, 63));
    endcase
  endfunction

  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_SIZE_EP1;
    cfg_data            <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.mode         <= MODE_REGISTER;
    req_ch.buf_addr     <= '0;
    req_ch.buf_location <= '0;
    req_ch.sub_select   <= SEL_EP1;
    take_pct = 30;
    set_idle_profile(0);
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // sizes chosen so the running sums wrap past 2^32
    write_sizes(SIZE_W'(32), SIZE_MAX, SIZE_MAX, SIZE_W'(2));
    send_req(MODE_TAKE, '0, '0, SEL_EP1);
    send_req(MODE_RET_TAIL, 32'h1234_5678, 32'h9abc_def0, SEL_EP1);
    send_req(MODE_RET_HEAD, 32'h1234_5678, 32'h9abc_def0, SEL_EP1);
    send_req(MODE_REGISTER, 32'h0000_0000, 32'hffff_ffff, SEL_EP1);
    send_req(MODE_TAKE, '0, '0, SEL_EP1);
    send_req(MODE_RET_HEAD, 32'hffff_ffe0, 32'h0000_001f, SEL_DATA);
    send_req(MODE_RET_TAIL, 32'h0f0f_0f0f, 32'hf0f0_f0f0, SEL_EP1);
    send_req(MODE_REGISTER, 32'hffff_ffff, 32'h0000_0000, SEL_WPP);
    send_req(MODE_TAKE, '0, '0, SEL_EP1);
    send_req(MODE_TAKE, '0, '0, SEL_EP1);
    send_req(MODE_TAKE, '0, '0, SEL_EP1);
    send_req(MODE_RET_TAIL, 32'h8000_0000, 32'h7fff_ffff, SEL_MAP);
    send_req(MODE_RET_HEAD, 32'h5555_5555, 32'haaaa_aaaa, SEL_EP2);
    send_req(MODE_TAKE, '0, '0, SEL_EP1);
    send_req(MODE_SUB, 32'h0000_0040, 32'hffff_ffe0, SEL_EP1);
    send_req(MODE_SUB, 32'h0000_0040, 32'hffff_ffe0, SEL_WPP);
    send_req(MODE_SUB, 32'h0000_0040, 32'hffff_ffe0, SEL_EP2);
    send_req(MODE_SUB, 32'h0000_0040, 32'hffff_ffe0, SEL_MAP);
    send_req(MODE_SUB, 32'h0000_0040, 32'hffff_ffe0, SEL_DATA);
    send_req(MODE_SUB, 32'h0000_0001, 32'h0000_0000, SEL_EP1);
    send_req(MODE_SUB, 32'h0000_0040, 32'h0000_0040, SEL_BAD_LO);
    send_req(MODE_SUB, 32'h0000_0040, 32'h0000_0040, SEL_BAD_HI);
    send_req(MODE_BAD_LO, 32'hdead_0000, 32'h0000_beef, SEL_DATA);
    send_req(MODE_BAD_HI, 32'hdead_0000, 32'h0000_beef, SEL_DATA);

    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      wait_drained();
      set_idle_profile(chunk / 2);
      write_sizes(pick_size(chunk), pick_size(chunk), pick_size(chunk), pick_size(chunk));
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        // swing the take share so the deque runs both full and empty
        if (i % 35 == 0) begin
          case ($urandom_range(0, 2))
            0: take_pct = 15;
            1: take_pct = 30;
            default: take_pct = 45;
          endcase
        end
        send_random();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("buffer_pool_ring_deque: match");
    end else begin
      $display("buffer_pool_ring_deque: mismatch");
    end
    $finish;
  end

endmodule
